// File: hw/rtl/sma_pkg.sv
// shared constants for the moving average block
`default_nettype none

package sma_pkg;

    // width of the window length register
    localparam int CFG_W = 6;

    // window length after reset
    localparam logic [CFG_W-1:0] WINDOW_RESET = 6'd7;

endpackage

`default_nettype wire

// File: hw/rtl/sma_ram.sv
// generic single write port, single read port ram with registered read
`default_nettype none

module sma_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [ADDR_W-1:0]        i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [ADDR_W-1:0]        i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// File: hw/rtl/sma_fifo.sv
// short queue between the front and back parts
`default_nettype none

module sma_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output      logic             o_full,
    input  wire logic             i_pop,
    output      logic             o_empty,
    output      logic [WIDTH-1:0] o_data
);

    // depth is a power of two so the pointers wrap on their own
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_slot [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_slot[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_slot[r_wr_ptr] <= i_data;
                r_wr_ptr         <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/sma_front.sv
// front part: accepts samples, tags each with slot, window and warm-up flag
`default_nettype none

module sma_front #(
    parameter int MAX_WINDOW  = 32,
    parameter int SAMPLE_BITS = 16,
    localparam int PTR_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1,
    localparam int WIN_W = $clog2(MAX_WINDOW + 1),
    localparam int JOB_W = SAMPLE_BITS + PTR_W + WIN_W + 1
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output      logic                          o_ready,
    input  wire logic [SAMPLE_BITS-1:0]        i_sample_count,
    input  wire logic [sma_pkg::CFG_W-1:0]     i_window_len,
    input  wire logic                          i_full,
    output      logic                          o_push,
    output      logic [JOB_W-1:0]              o_job
);

    localparam int CMP_W = (WIN_W > sma_pkg::CFG_W) ? WIN_W : sma_pkg::CFG_W;

    logic [PTR_W-1:0] r_write_pos;
    logic [WIN_W-1:0] r_items_seen;

    logic [CMP_W-1:0] len_wide;
    logic [WIN_W-1:0] win;
    logic             win_ok;
    logic             accept;

    // clamp the register to 1..MAX_WINDOW
    always_comb begin
        len_wide = CMP_W'(i_window_len);
        if (len_wide == '0) begin
            win = WIN_W'(1);
        end else if (len_wide > CMP_W'(MAX_WINDOW)) begin
            win = WIN_W'(MAX_WINDOW);
        end else begin
            win = len_wide[WIN_W-1:0];
        end
    end

    assign win_ok  = (r_items_seen >= win);
    assign o_ready = !i_full;
    assign accept  = i_valid && o_ready;
    assign o_push  = accept;
    assign o_job   = {i_sample_count, r_write_pos, win, win_ok};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_write_pos  <= '0;
            r_items_seen <= '0;
        end else if (accept) begin
            if (r_write_pos == PTR_W'(MAX_WINDOW - 1)) begin
                r_write_pos <= '0;
            end else begin
                r_write_pos <= r_write_pos + 1'b1;
            end
            if (r_items_seen != WIN_W'(MAX_WINDOW)) begin
                r_items_seen <= r_items_seen + 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/sma_back.sv
// back part: writes the history ring, sums the window and divides (both skipped in warm-up), holds the result
`default_nettype none

module sma_back #(
    parameter int MAX_WINDOW  = 32,
    parameter int SAMPLE_BITS = 16,
    localparam int PTR_W  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1,
    localparam int WIN_W  = $clog2(MAX_WINDOW + 1),
    localparam int JOB_W  = SAMPLE_BITS + PTR_W + WIN_W + 1
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_job_avail,
    input  wire logic [JOB_W-1:0]       i_job,
    output      logic                   o_job_pop,
    output      logic                   o_valid,
    input  wire logic                   i_ready,
    output      logic [SAMPLE_BITS-1:0] o_average,
    output      logic                   o_avg_valid
);

    localparam int SUM_W  = SAMPLE_BITS + PTR_W;
    localparam int STEP_W = $clog2(SUM_W + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_WRITE,
        S_SUM,
        S_DIV,
        S_OUT
    } t_state;

    t_state                 r_state;
    logic [SAMPLE_BITS-1:0] r_sample;
    logic [PTR_W-1:0]       r_pos;
    logic [WIN_W-1:0]       r_win;
    logic                   r_ok;
    logic [PTR_W-1:0]       r_rd_addr;
    logic [WIN_W-1:0]       r_issued;
    logic                   r_pend;
    logic                   r_rd_ok;
    logic [SUM_W-1:0]       r_acc;
    logic [WIN_W-1:0]       r_rem;
    logic [SUM_W-1:0]       r_quo;
    logic [STEP_W-1:0]      r_step;
    logic [MAX_WINDOW-1:0]  r_slot_valid;
    logic                   r_out_valid;
    logic [SAMPLE_BITS-1:0] r_average;
    logic                   r_avg_valid;

    logic [SAMPLE_BITS-1:0] rd_data;
    logic                   ram_we;
    logic                   issue;
    logic                   out_free;
    logic [WIN_W:0]         n_shift;
    logic [WIN_W:0]         n_diff;
    logic                   n_bit;

    sma_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_WINDOW)
    ) u_history (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_pos),
        .i_wdata (r_sample),
        .i_raddr (r_rd_addr),
        .o_rdata (rd_data)
    );

    assign ram_we    = (r_state == S_WRITE);
    assign o_job_pop = (r_state == S_IDLE) && i_job_avail;
    assign issue     = (r_issued != r_win);
    assign out_free  = !r_out_valid || i_ready;

    // one restoring division step
    always_comb begin
        n_shift = {r_rem, r_quo[SUM_W-1]};
        n_diff  = n_shift - {1'b0, r_win};
        n_bit   = (n_shift >= {1'b0, r_win});
    end

    assign o_valid     = r_out_valid;
    assign o_average   = r_average;
    assign o_avg_valid = r_avg_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_slot_valid <= '0;
            r_out_valid  <= 1'b0;
            r_pend       <= 1'b0;
        end else begin
            // slot flag travels with the registered ram read
            r_rd_ok <= r_slot_valid[r_rd_addr];
            if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_job_avail) begin
                        {r_sample, r_pos, r_win, r_ok} <= i_job;
                        r_state <= S_WRITE;
                    end
                end
                S_WRITE: begin
                    r_slot_valid[r_pos] <= 1'b1;
                    r_rd_addr <= r_pos;
                    r_issued  <= '0;
                    r_pend    <= 1'b0;
                    r_acc     <= '0;
                    r_quo     <= '0;
                    r_state   <= r_ok ? S_SUM : S_OUT;
                end
                S_SUM: begin
                    // newest slot first, walking back around the ring
                    if (issue) begin
                        if (r_rd_addr == '0) begin
                            r_rd_addr <= PTR_W'(MAX_WINDOW - 1);
                        end else begin
                            r_rd_addr <= r_rd_addr - 1'b1;
                        end
                        r_issued <= r_issued + 1'b1;
                    end
                    r_pend <= issue;
                    if (r_pend && r_rd_ok) begin
                        r_acc <= r_acc + SUM_W'(rd_data);
                    end
                    if (!issue && !r_pend) begin
                        r_quo   <= r_acc;
                        r_rem   <= '0;
                        r_step  <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_rem  <= n_bit ? n_diff[WIN_W-1:0] : n_shift[WIN_W-1:0];
                    r_quo  <= {r_quo[SUM_W-2:0], n_bit};
                    r_step <= r_step + 1'b1;
                    if (r_step == STEP_W'(SUM_W - 1)) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_average   <= r_quo[SAMPLE_BITS-1:0];
                        r_avg_valid <= r_ok;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/simple_moving_average.sv
// simple moving average filter: top level
// path from transfer in to result: queue, history ring write, sum over the newest w slots,
//   w being the clamped window length, then bit-serial divide and output register;
//   a warm-up item skips the sum and divide
// the back part finishes each item before taking the next, paced by the history ram
//   read port walk (one slot a cycle) and the bit-serial divider (one quotient bit a cycle)
// reset (sync, active low): queue, counters and slot flags clear, so history reads as zero;
//   window length returns to 7; no clearing pass is needed
`default_nettype none

module simple_moving_average #(
    parameter int MAX_WINDOW  = 32,
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    // configuration write
    input  wire logic                      i_cfg_we,
    input  wire logic [sma_pkg::CFG_W-1:0] i_cfg_wdata,
    // sample input channel
    input  wire logic                      i_valid,
    output      logic                      o_ready,
    input  wire logic [SAMPLE_BITS-1:0]    i_sample_count,
    // result channel
    output      logic                      o_valid,
    input  wire logic                      i_ready,
    output      logic [SAMPLE_BITS-1:0]    o_average,
    output      logic                      o_avg_valid
);

    localparam int PTR_W     = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int WIN_W     = $clog2(MAX_WINDOW + 1);
    localparam int JOB_W     = SAMPLE_BITS + PTR_W + WIN_W + 1;
    localparam int Q_DEPTH   = 2;

    logic [sma_pkg::CFG_W-1:0] r_window_len;

    logic             q_full;
    logic             q_empty;
    logic             q_push;
    logic             q_pop;
    logic [JOB_W-1:0] q_in;
    logic [JOB_W-1:0] q_out;

    // window length register: the user must write it only while the block is idle; the block does not enforce it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_len <= sma_pkg::WINDOW_RESET;
        end else if (i_cfg_we) begin
            r_window_len <= i_cfg_wdata;
        end
    end

    // front: takes the transfer, assigns the ring slot, clamps the window
    // and decides warm-up from the saturating item count
    sma_front #(
        .MAX_WINDOW  (MAX_WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_sample_count (i_sample_count),
        .i_window_len   (r_window_len),
        .i_full         (q_full),
        .o_push         (q_push),
        .o_job          (q_in)
    );

    // two-entry queue lets the front keep taking samples while the back is busy
    sma_fifo #(
        .WIDTH (JOB_W),
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  (q_out)
    );

    // back: ring write, window sum, divide, output register
    sma_back #(
        .MAX_WINDOW  (MAX_WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_avail (!q_empty),
        .i_job       (q_out),
        .o_job_pop   (q_pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_average   (o_average),
        .o_avg_valid (o_avg_valid)
    );

endmodule

`default_nettype wire

// File: hw/rtl/sma_checker.sv
// port-level checks for the moving average block, bound to the top level
`default_nettype none

module sma_checker #(
    parameter int SAMPLE_BITS = 16
) (
    input wire logic                   i_clk,
    input wire logic                   i_rst_n,
    input wire logic                   i_valid,
    input wire logic                   o_ready,
    input wire logic                   o_valid,
    input wire logic                   i_ready,
    input wire logic [SAMPLE_BITS-1:0] o_average,
    input wire logic                   o_avg_valid
);

    logic [3:0] r_inflight;
    logic       in_xfer;
    logic       out_xfer;

    assign in_xfer  = i_valid && o_ready;
    assign out_xfer = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= '0;
        end else begin
            r_inflight <= r_inflight + {3'b000, in_xfer} - {3'b000, out_xfer};
        end
    end

    // a held result does not change until it is taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_average) && $stable(o_avg_valid))
        else $error("result changed while stalled");

    // warm-up results carry a zero average
    a_warmup_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_avg_valid |-> o_average == '0)
        else $error("nonzero average during warm-up");

    // every result stems from an earlier sample transfer
    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> r_inflight != '0)
        else $error("result without a pending sample");

    // reset leaves no result showing
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind simple_moving_average sma_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_sma_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_ready     (o_ready),
    .o_valid     (o_valid),
    .i_ready     (i_ready),
    .o_average   (o_average),
    .o_avg_valid (o_avg_valid)
);

`default_nettype wire

// File: bench/tb_top.sv
// testbench for the simple moving average filter: a directed table, then random window phases
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_WIN       = 32;
    localparam int SAMPLE_W      = 16;
    localparam int N_DIRECTED    = 21;
    localparam int RANDOM_ITEMS  = 1630;
    // covers the slowest items, at a full window, plus sender gaps and receiver stalls
    localparam int LIMIT_CYCLES  = 1_000_000;
    localparam int HOLD_CYCLES   = 2000;
    // every item gives a result, so a short pause is enough before a window write
    localparam int SETTLE_CYCLES = 8;
    // latency at the largest window, with margin
    localparam int DRAIN_CYCLES  = 70;

    typedef struct {
        logic [SAMPLE_W-1:0] average;
        logic                avg_valid;
    } t_avg_result;

    // one row of the directed part: optional window write, then one sample;
    // typed rows carry their expected result, the rest go through the predictor
    typedef struct {
        bit                        load_window;
        logic [sma_pkg::CFG_W-1:0] window;
        logic [SAMPLE_W-1:0]       sample;
        bit                        typed;
        logic [SAMPLE_W-1:0]       average;
        logic                      avg_valid;
    } t_table_row;

    // receiver stall patterns
    typedef enum logic [1:0] {
        RDY_ALWAYS,
        RDY_COIN,
        RDY_SPARSE,
        RDY_EVERY_THIRD
    } t_ready_mode;

    // block ports; the inputs are driven to known values from time zero
    logic                      i_clk          = 1'b0;
    logic                      i_rst_n        = 1'b0;
    logic                      i_cfg_we       = 1'b0;
    logic [sma_pkg::CFG_W-1:0] i_cfg_wdata    = '0;
    logic                      i_valid        = 1'b0;
    logic                      o_ready;
    logic [SAMPLE_W-1:0]       i_sample_count = '0;
    logic                      o_valid;
    logic                      i_ready        = 1'b0;
    logic [SAMPLE_W-1:0]       o_average;
    logic                      o_avg_valid;

    simple_moving_average #(
        .MAX_WINDOW (MAX_WIN),
        .SAMPLE_BITS(SAMPLE_W)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_sample_count(i_sample_count),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_average     (o_average),
        .o_avg_valid   (o_avg_valid)
    );

    always #5 i_clk = ~i_clk;

    // predictor state: sample ring, next slot, saturating item count, window register
    logic [SAMPLE_W-1:0]       ring [MAX_WIN];
    logic [4:0]                ring_pos;
    logic [5:0]                seen_count;
    logic [sma_pkg::CFG_W-1:0] window_reg;

    // expected averages, oldest first
    t_avg_result pending_averages [$];
    int          mismatch_count = 0;

    // long receiver hold-off: main process asks, receiver process serves
    int hold_asked  = 0;
    int hold_served = 0;
    int hold_left   = 0;

    // sender burst bookkeeping
    int burst_left = 0;

    t_table_row directed_rows [N_DIRECTED] = '{
        // warm-up at the reset window of 7: all zero, flag clear
        '{1'b0, 6'd0,  16'hFFFF, 1'b1, 16'h0000, 1'b0},
        '{1'b0, 6'd0,  16'hFFFF, 1'b1, 16'h0000, 1'b0},
        '{1'b0, 6'd0,  16'hFFFF, 1'b1, 16'h0000, 1'b0},
        '{1'b0, 6'd0,  16'hFFFF, 1'b1, 16'h0000, 1'b0},
        '{1'b0, 6'd0,  16'hFFFF, 1'b1, 16'h0000, 1'b0},
        '{1'b0, 6'd0,  16'hFFFF, 1'b1, 16'h0000, 1'b0},
        '{1'b0, 6'd0,  16'hFFFF, 1'b1, 16'h0000, 1'b0},
        // first full window of max samples: largest sum
        '{1'b0, 6'd0,  16'hFFFF, 1'b1, 16'hFFFF, 1'b1},
        '{1'b0, 6'd0,  16'h0000, 1'b0, 16'h0000, 1'b0},
        // window of zero acts as one: average is the sample itself
        '{1'b1, 6'd0,  16'h0000, 1'b1, 16'h0000, 1'b1},
        '{1'b0, 6'd0,  16'hFFFF, 1'b1, 16'hFFFF, 1'b1},
        '{1'b1, 6'd1,  16'h3039, 1'b1, 16'h3039, 1'b1},
        // above the maximum acts as 32: back into warm-up
        '{1'b1, 6'd63, 16'hFFFF, 1'b1, 16'h0000, 1'b0},
        '{1'b1, 6'd32, 16'h0001, 1'b1, 16'h0000, 1'b0},
        // window shrunk mid-stream
        '{1'b1, 6'd2,  16'hFFFF, 1'b0, 16'h0000, 1'b0},
        '{1'b0, 6'd0,  16'h8000, 1'b0, 16'h0000, 1'b0},
        '{1'b0, 6'd0,  16'h5555, 1'b0, 16'h0000, 1'b0},
        '{1'b0, 6'd0,  16'hAAAA, 1'b0, 16'h0000, 1'b0},
        '{1'b0, 6'd0,  16'h0001, 1'b0, 16'h0000, 1'b0},
        '{1'b1, 6'd33, 16'h0000, 1'b1, 16'h0000, 1'b0},
        '{1'b1, 6'd7,  16'h7FFF, 1'b0, 16'h0000, 1'b0}
    };

    // store the sample, sum the newest slots walking back, divide by the clamped window (zero in warm-up)
    function automatic t_avg_result next_average(input logic [SAMPLE_W-1:0] s);
        int          w;
        logic [20:0] total;
        logic [4:0]  p;
        t_avg_result r;
        // zero means one, anything past the ring size means the whole ring
        w = (window_reg == 0) ? 1 : (window_reg > MAX_WIN) ? MAX_WIN : int'(window_reg);
        ring[ring_pos] = s;
        total = '0;
        p = ring_pos;
        for (int j = 0; j < w; j++) begin
            total += 21'(ring[p]);
            p = p - 5'd1;
        end
        r.avg_valid = (int'(seen_count) >= w);
        r.average   = r.avg_valid ? 16'(total / 21'(w)) : '0;
        ring_pos = ring_pos + 5'd1;
        if (seen_count < MAX_WIN) begin
            seen_count = seen_count + 6'd1;
        end
        return r;
    endfunction

    // mostly small windows keep the run short; extremes and out-of-range codes now and then
    function automatic logic [sma_pkg::CFG_W-1:0] pick_window();
        case ($urandom_range(0, 11))
            0: return 6'd0;
            1: return 6'd1;
            2: return 6'd32;
            3: return 6'($urandom_range(33, 63));
            4: return 6'd63;
            5: return 6'($urandom_range(9, 32));
            default: return 6'($urandom_range(1, 8));
        endcase
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'($urandom_range(0, 15));
            3: return 16'hFFFF - 16'($urandom_range(0, 15));
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    // sender works in bursts: zero gap inside a burst, a random gap before the next one
    function automatic int next_gap();
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        burst_left = $urandom_range(0, 40);
        case ($urandom_range(0, 3))
            0: return 0;
            1: return $urandom_range(1, 3);
            default: return $urandom_range(4, 60);
        endcase
    endfunction

    // offer one sample after an optional gap and wait for its transfer;
    // valid stays high afterwards so back-to-back items need no second assignment
    task automatic send_sample(input logic [SAMPLE_W-1:0] s, input int gap,
                               input bit typed, input t_avg_result typed_res);
        t_avg_result r;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_sample_count <= s;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        // transfer took place at this edge: advance the predictor
        r = next_average(s);
        pending_averages.push_back(typed ? typed_res : r);
    endtask

    // window writes only while the block is idle: every result back, then a short pause
    task automatic load_window(input logic [sma_pkg::CFG_W-1:0] v);
        i_valid <= 1'b0;
        while (pending_averages.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        window_reg = v;
    endtask

    // main stimulus
    initial begin
        t_avg_result               typed_res;
        int                        phase;
        int                        sent;
        int                        phase_len;
        logic [sma_pkg::CFG_W-1:0] w;

        // predictor after reset
        foreach (ring[i]) ring[i] = '0;
        ring_pos   = '0;
        seen_count = '0;
        window_reg = sma_pkg::WINDOW_RESET;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        foreach (directed_rows[k]) begin
            if (directed_rows[k].load_window) begin
                load_window(directed_rows[k].window);
            end
            typed_res.average   = directed_rows[k].average;
            typed_res.avg_valid = directed_rows[k].avg_valid;
            send_sample(directed_rows[k].sample, $urandom_range(0, 5),
                        directed_rows[k].typed, typed_res);
        end

        // random phases, each with its own window length
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS) begin
            if (phase == 1) begin
                // short window and a long phase for the receiver hold-off
                w         = 6'd3;
                phase_len = 200;
            end else begin
                w         = pick_window();
                phase_len = $urandom_range(40, 110);
            end
            load_window(w);
            if (phase == 1) begin
                // sender keeps offering while the receiver sits still, so the block backs up
                hold_asked <= hold_asked + 1;
            end
            for (int n = 0; n < phase_len && sent < RANDOM_ITEMS; n++) begin
                send_sample(pick_sample(), next_gap(), 1'b0, typed_res);
                sent++;
            end
            phase++;
        end
        i_valid <= 1'b0;

        // drain, then a latency's worth of quiet cycles to catch stray results
        while (pending_averages.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && pending_averages.size() == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

    // receiver: stall patterns of random length, plus the one long hold-off on request
    t_ready_mode rdy_mode  = RDY_ALWAYS;
    int          mode_left = 0;
    int          third_cnt = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (hold_left > 0) begin
            i_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_asked != hold_served) begin
            hold_served <= hold_asked;
            hold_left   <= HOLD_CYCLES;
            i_ready     <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                rdy_mode  <= t_ready_mode'($urandom_range(0, 3));
                mode_left <= $urandom_range(16, 300);
            end else begin
                mode_left <= mode_left - 1;
            end
            third_cnt <= (third_cnt == 2) ? 0 : third_cnt + 1;
            case (rdy_mode)
                RDY_ALWAYS:      i_ready <= 1'b1;
                RDY_COIN:        i_ready <= 1'($urandom_range(0, 1));
                RDY_SPARSE:      i_ready <= ($urandom_range(0, 3) == 0);
                RDY_EVERY_THIRD: i_ready <= (third_cnt == 0);
                default:         i_ready <= 1'b1;
            endcase
        end
    end

    // result checker: each transfer out against the oldest expectation
    always @(posedge i_clk) begin
        t_avg_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_averages.size() == 0) begin
                if (mismatch_count < 10) begin
                    $display("unexpected result: average=%0d avg_valid=%0d",
                             o_average, o_avg_valid);
                end
                mismatch_count++;
            end else begin
                want = pending_averages.pop_front();
                if (o_average !== want.average || o_avg_valid !== want.avg_valid) begin
                    if (mismatch_count < 10) begin
                        $display("mismatch: average exp %0d got %0d, avg_valid exp %0d got %0d",
                                 want.average, o_average, want.avg_valid, o_avg_valid);
                    end
                    mismatch_count++;
                end
            end
        end
    end

    // watchdog
    initial begin
        int cycle_count;
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("tb_top failed");
        $finish;
    end

endmodule
